// File: rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types, character codes and command templates for the serial
// command parser.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam logic [7:0] CH_OPEN    = 8'h28;
  localparam logic [7:0] CH_CLOSE   = 8'h29;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] DIGIT_BASE = 8'd48;
  localparam logic [7:0] DIGIT_TOP  = 8'd57;

  // Width of the decimal accumulator: three digits reach 999.
  localparam int unsigned VAL_W    = 10;
  localparam logic [VAL_W-1:0] STEP_MAX = VAL_W'(255);

  // Characters checked ahead of the closing paren for each command.
  localparam int unsigned START_CHARS = 6;
  localparam int unsigned STOP_CHARS  = 5;
  localparam int unsigned M1_CHARS    = 3;
  localparam int unsigned M2_CHARS    = 4;

  // Position of the closing paren for each command.
  localparam int unsigned START_CLOSE  = 6;
  localparam int unsigned STOP_CLOSE   = 5;
  localparam int unsigned M1_CLOSE     = 3;
  localparam int unsigned M2_CLOSE_MIN = 5;
  localparam int unsigned M2_CLOSE_MAX = 7;

  // Positions that may hold mode-2 value digits.
  localparam int unsigned DIGIT_FIRST = 4;
  localparam int unsigned DIGIT_LAST  = 6;

  // Cells that take part in the match chain.
  localparam int unsigned MATCH_CELLS = 8;

  typedef enum logic [2:0] {
    RESP_STARTED  = 3'd0,
    RESP_STOPPED  = 3'd1,
    RESP_MODE1    = 3'd2,
    RESP_MODE2    = 3'd3,
    RESP_FORMAT   = 3'd4,
    RESP_OVERFLOW = 3'd5
  } resp_e;

  localparam logic [1:0] MODE_ONE = 2'd1;
  localparam logic [1:0] MODE_TWO = 2'd2;

  // Running match state handed from one cell to the next.
  typedef struct packed {
    logic             start_ok;
    logic             stop_ok;
    logic             m1_ok;
    logic             m2_ok;
    logic             fmt_bad;
    logic [VAL_W-1:0] value;
  } chain_t;

  function automatic logic [7:0] start_char(input int unsigned idx);
    logic [7:0] ch;
    case (idx)
      0:       ch = CH_OPEN;
      1:       ch = 8'h53; // S
      2:       ch = 8'h54; // T
      3:       ch = 8'h41; // A
      4:       ch = 8'h52; // R
      5:       ch = 8'h54; // T
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] stop_char(input int unsigned idx);
    logic [7:0] ch;
    case (idx)
      0:       ch = CH_OPEN;
      1:       ch = 8'h53; // S
      2:       ch = 8'h54; // T
      3:       ch = 8'h4F; // O
      4:       ch = 8'h50; // P
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] m1_char(input int unsigned idx);
    logic [7:0] ch;
    case (idx)
      0:       ch = CH_OPEN;
      1:       ch = 8'h4D; // M
      2:       ch = 8'h31; // 1
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] m2_char(input int unsigned idx);
    logic [7:0] ch;
    case (idx)
      0:       ch = CH_OPEN;
      1:       ch = 8'h4D; // M
      2:       ch = 8'h32; // 2
      3:       ch = CH_COLON;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/scp_in_if.sv
// ----------------------------------------------------------------------------
// scp_in_if
// Received byte channel: valid/ready handshake with one byte per word.
// ----------------------------------------------------------------------------
interface scp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/scp_out_if.sv
// ----------------------------------------------------------------------------
// scp_out_if
// Command result channel: valid/ready handshake with response and status.
// ----------------------------------------------------------------------------
interface scp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] response;
  logic       running;
  logic [1:0] mode_now;
  logic [7:0] step_count;
  logic       clear_counter;
  logic       error_sticky;

  modport source (
    output valid, output response, output running, output mode_now,
    output step_count, output clear_counter, output error_sticky,
    input  ready
  );
  modport sink (
    input  valid, input response, input running, input mode_now,
    input  step_count, input clear_counter, input error_sticky,
    output ready
  );
endinterface

// File: rtl/scp_cell.sv
// ----------------------------------------------------------------------------
// scp_cell
// One message byte. Folds its byte into the match state coming from the
// cell on its left and hands the result to the cell on its right.
// ----------------------------------------------------------------------------
module scp_cell #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned PosW = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [7:0]          wdata_i,
  input  logic [PosW-1:0]     close_pos_i,
  input  scp_pkg::chain_t     chain_i,
  output scp_pkg::chain_t     chain_o
);
  import scp_pkg::*;

  localparam logic [7:0] StartCh = start_char(IDX);
  localparam logic [7:0] StopCh  = stop_char(IDX);
  localparam logic [7:0] M1Ch    = m1_char(IDX);
  localparam logic [7:0] M2Ch    = m2_char(IDX);
  localparam bit InStart = IDX < START_CHARS;
  localparam bit InStop  = IDX < STOP_CHARS;
  localparam bit InM1    = IDX < M1_CHARS;
  localparam bit InM2    = IDX < M2_CHARS;
  localparam bit InDigit = (IDX >= DIGIT_FIRST) && (IDX <= DIGIT_LAST);

  logic [7:0]       byte_q;
  logic [7:0]       diff;
  logic             is_digit;
  logic             digit_active;
  logic [VAL_W-1:0] scaled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (we_i) begin
      byte_q <= wdata_i;
    end
  end

  assign diff         = byte_q - DIGIT_BASE;
  assign is_digit     = (byte_q >= DIGIT_BASE) && (byte_q <= DIGIT_TOP);
  // only digits ahead of the closing paren count
  assign digit_active = InDigit && (close_pos_i > PosW'(IDX));
  assign scaled       = (chain_i.value << 3) + (chain_i.value << 1);

  always_comb begin
    chain_o.start_ok = chain_i.start_ok & (!InStart | (byte_q == StartCh));
    chain_o.stop_ok  = chain_i.stop_ok  & (!InStop  | (byte_q == StopCh));
    chain_o.m1_ok    = chain_i.m1_ok    & (!InM1    | (byte_q == M1Ch));
    chain_o.m2_ok    = chain_i.m2_ok    & (!InM2    | (byte_q == M2Ch));
    chain_o.fmt_bad  = chain_i.fmt_bad  | (digit_active & !is_digit);
    chain_o.value    = digit_active ? scaled + VAL_W'(diff[3:0]) : chain_i.value;
  end

endmodule

// File: rtl/serial_command_parser.sv
// ----------------------------------------------------------------------------
// serial_command_parser
// Stores received bytes in a row of byte cells and decodes a command when
// the closing paren arrives.
// ----------------------------------------------------------------------------
// A result word is registered: it is valid in the cycle after its closing-paren byte is taken.
// Throughput: one byte per cycle while no held result stalls input; the match
// runs along the cell chain in the same cycle the closing paren is taken.
// A held result word only stalls input while it is not being taken.
// Reset: async active low; clears the store, write position and flags,
// mode returns to 1.
module serial_command_parser #(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  scp_in_if.sink           rx_i,
  scp_out_if.source        resp_o
);
  import scp_pkg::*;

  localparam int unsigned PW = $clog2(BUFFER_DEPTH);

  logic [PW-1:0] wp_q, wp_d;
  logic          run_q, run_d;
  logic [1:0]    mode_q, mode_d;
  logic [7:0]    steps_q, steps_d;
  logic          err_q, err_d;

  logic          out_valid_q;
  resp_e         out_resp_q;
  logic          out_run_q;
  logic [1:0]    out_mode_q;
  logic [7:0]    out_steps_q;
  logic          out_clr_q;
  logic          out_err_q;

  logic          accept;
  logic          is_open;
  logic          is_close;
  logic          dec;
  logic [PW-1:0] pos;
  logic [PW:0]   pos_inc;
  chain_t        chain [BUFFER_DEPTH+1];
  chain_t        chain_end;

  resp_e         resp;
  logic          clr;
  logic          start_hit, stop_hit, m1_hit, m2_hit;

  assign rx_i.ready = !out_valid_q || resp_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;
  assign is_open    = rx_i.rx_byte == CH_OPEN;
  assign is_close   = rx_i.rx_byte == CH_CLOSE;
  assign dec        = accept && is_close;
  assign pos        = is_open ? '0 : wp_q;
  assign pos_inc    = {1'b0, pos} + (PW+1)'(1);

  always_comb begin
    if (is_close) begin
      wp_d = PW'(1);
    end else if (pos_inc == (PW+1)'(BUFFER_DEPTH)) begin
      wp_d = '0;
    end else begin
      wp_d = pos_inc[PW-1:0];
    end
  end

  assign chain[0] = '{start_ok: 1'b1, stop_ok: 1'b1, m1_ok: 1'b1, m2_ok: 1'b1,
                      fmt_bad: 1'b0, value: '0};

  for (genvar g = 0; g < BUFFER_DEPTH; g++) begin : g_cell
    logic       cell_we;
    logic [7:0] cell_wdata;
    // entry 0 is cleared after each decode
    assign cell_we    = (accept && (pos == PW'(g))) || ((g == 0) && dec);
    assign cell_wdata = ((g == 0) && dec) ? 8'h00 : rx_i.rx_byte;

    scp_cell #(
      .IDX  (g),
      .PosW (PW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .we_i        (cell_we),
      .wdata_i     (cell_wdata),
      .close_pos_i (pos),
      .chain_i     (chain[g]),
      .chain_o     (chain[g+1])
    );
  end

  assign chain_end = chain[MATCH_CELLS];

  assign start_hit = chain_end.start_ok && (pos == PW'(START_CLOSE));
  assign stop_hit  = chain_end.stop_ok  && (pos == PW'(STOP_CLOSE));
  assign m1_hit    = chain_end.m1_ok    && (pos == PW'(M1_CLOSE));
  assign m2_hit    = chain_end.m2_ok    && (pos >= PW'(M2_CLOSE_MIN))
                                        && (pos <= PW'(M2_CLOSE_MAX));

  always_comb begin
    run_d   = run_q;
    mode_d  = mode_q;
    steps_d = steps_q;
    err_d   = err_q;
    clr     = 1'b0;
    resp    = RESP_FORMAT;
    if (start_hit) begin
      run_d  = 1'b1;
      mode_d = MODE_ONE;
      resp   = RESP_STARTED;
    end else if (stop_hit) begin
      run_d   = 1'b0;
      steps_d = '0;
      clr     = 1'b1;
      resp    = RESP_STOPPED;
    end else if (m1_hit) begin
      mode_d = MODE_ONE;
      resp   = RESP_MODE1;
    end else if (m2_hit) begin
      if (chain_end.fmt_bad) begin
        err_d = 1'b1;
        resp  = RESP_FORMAT;
      end else if (chain_end.value > STEP_MAX) begin
        err_d = 1'b1;
        resp  = RESP_OVERFLOW;
      end else begin
        mode_d  = MODE_TWO;
        steps_d = chain_end.value[7:0];
        resp    = RESP_MODE2;
      end
    end else begin
      err_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      run_q   <= 1'b0;
      mode_q  <= MODE_ONE;
      steps_q <= '0;
      err_q   <= 1'b0;
    end else if (accept) begin
      wp_q <= wp_d;
      if (is_close) begin
        run_q   <= run_d;
        mode_q  <= mode_d;
        steps_q <= steps_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dec) begin
      out_valid_q <= 1'b1;
    end else if (resp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec) begin
      out_resp_q  <= resp;
      out_run_q   <= run_d;
      out_mode_q  <= mode_d;
      out_steps_q <= steps_d;
      out_clr_q   <= clr;
      out_err_q   <= err_d;
    end
  end

  assign resp_o.valid         = out_valid_q;
  assign resp_o.response      = out_resp_q;
  assign resp_o.running       = out_run_q;
  assign resp_o.mode_now      = out_mode_q;
  assign resp_o.step_count    = out_steps_q;
  assign resp_o.clear_counter = out_clr_q;
  assign resp_o.error_sticky  = out_err_q;

endmodule

// File: rtl/scp_checker.sv
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks on the result channel of the serial command parser.
// ----------------------------------------------------------------------------
module scp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] response_i,
  input logic       running_i,
  input logic [1:0] mode_now_i,
  input logic [7:0] step_count_i,
  input logic       clear_counter_i,
  input logic       error_sticky_i
);
  import scp_pkg::*;

  // a stalled word stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(response_i)
      && $stable(step_count_i) && $stable(mode_now_i))
    else $error("result word changed while stalled");

  a_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (mode_now_i == MODE_ONE) || (mode_now_i == MODE_TWO))
    else $error("mode out of range");

  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && clear_counter_i |->
      (response_i == RESP_STOPPED) && !running_i && (step_count_i == 8'd0))
    else $error("count clear without a clean stop");

  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((response_i == RESP_FORMAT) || (response_i == RESP_OVERFLOW))
      |-> error_sticky_i)
    else $error("error response without sticky flag");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (response_i == RESP_STARTED) |-> running_i && (mode_now_i == MODE_ONE))
    else $error("start did not leave the block running in mode 1");

endmodule

bind serial_command_parser scp_checker u_scp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (resp_o.valid),
  .out_ready_i     (resp_o.ready),
  .response_i      (resp_o.response),
  .running_i       (resp_o.running),
  .mode_now_i      (resp_o.mode_now),
  .step_count_i    (resp_o.step_count),
  .clear_counter_i (resp_o.clear_counter),
  .error_sticky_i  (resp_o.error_sticky)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for serial_command_parser. Bytes of well-formed,
// damaged and noisy command lines go in over the rx channel. A model of the
// parser in the bench predicts each command result, and every result word
// taken from the response channel is compared against it. Handshake pressure
// on both sides changes from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;
  import scp_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned PHASE_LEN  = 440;
  localparam int unsigned HOLD_LEN   = 200;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned MAX_REPORT = 10;

  typedef struct {
    resp_e      response;
    logic       running;
    logic [1:0] mode_now;
    logic [7:0] step_count;
    logic       clear_counter;
    logic       error_sticky;
  } cmd_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  scp_in_if  rx_if ();
  scp_out_if resp_if ();

  serial_command_parser #(.BUFFER_DEPTH(DEPTH)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .resp_o (resp_if)
  );

  always #5 clk_i = ~clk_i;

  // Bench copy of the parser state
  logic [7:0]  line_buf [DEPTH];
  int unsigned wr_idx = 0;
  logic        run_q = 1'b0;
  logic [1:0]  mode_q = MODE_ONE;
  logic [7:0]  steps_q = 8'd0;
  logic        err_q = 1'b0;

  cmd_result_t result_q [$];
  logic [7:0]  tx_bytes [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cnt = 0;
  int unsigned bytes_queued = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned resp_count [6];
  logic        rx_took = 1'b0;

  function automatic bit head_is(string s);
    for (int i = 0; i < s.len(); i++) begin
      if (line_buf[i] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void take_byte(logic [7:0] b);
    cmd_result_t r;
    int unsigned len;
    int unsigned val;
    bit          bad;
    if (b == CH_OPEN) wr_idx = 0;
    line_buf[wr_idx] = b;
    if (b != CH_CLOSE) begin
      wr_idx = (wr_idx + 1) % DEPTH;
      return;
    end
    // only the bytes up to the close paren take part, stale tail ignored
    len = wr_idx + 1;
    r.clear_counter = 1'b0;
    if (len == 7 && head_is("(START)")) begin
      run_q      = 1'b1;
      mode_q     = MODE_ONE;
      r.response = RESP_STARTED;
    end else if (len == 6 && head_is("(STOP)")) begin
      run_q           = 1'b0;
      steps_q         = 8'd0;
      r.clear_counter = 1'b1;
      r.response      = RESP_STOPPED;
    end else if (len == 4 && head_is("(M1)")) begin
      mode_q     = MODE_ONE;
      r.response = RESP_MODE1;
    end else if (len >= 6 && len <= 8 && head_is("(M2:")) begin
      val = 0;
      bad = 1'b0;
      for (int i = 4; i < len - 1; i++) begin
        if (line_buf[i] < DIGIT_BASE || line_buf[i] > DIGIT_TOP) bad = 1'b1;
        else val = val * 10 + (line_buf[i] - DIGIT_BASE);
      end
      if (bad) begin
        err_q      = 1'b1;
        r.response = RESP_FORMAT;
      end else if (val > STEP_MAX) begin
        err_q      = 1'b1;
        r.response = RESP_OVERFLOW;
      end else begin
        mode_q     = MODE_TWO;
        steps_q    = 8'(val);
        r.response = RESP_MODE2;
      end
    end else begin
      err_q      = 1'b1;
      r.response = RESP_FORMAT;
    end
    line_buf[0]    = 8'd0;
    wr_idx         = 1 % DEPTH;
    r.running      = run_q;
    r.mode_now     = mode_q;
    r.step_count   = steps_q;
    r.error_sticky = err_q;
    result_q.push_back(r);
  endfunction

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      tx_bytes.push_back(s[i]);
      bytes_queued++;
    end
  endtask

  // One command line, usually well formed, sometimes damaged or pure noise
  task automatic push_random_cmd();
    logic [7:0]  msg [$];
    string       txt;
    int unsigned pick;
    int unsigned val;
    int unsigned pos;
    logic [7:0]  b;
    case ($urandom_range(0, 5))
      0: txt = "(START)";
      1: txt = "(STOP)";
      2: txt = "(M1)";
      default: begin
        case ($urandom_range(0, 7))
          0:       val = 255;
          1:       val = 256;
          2:       val = 0;
          3:       val = 999;
          default: val = $urandom_range(0, 999);
        endcase
        if ($urandom_range(0, 3) == 0) txt = $sformatf("(M2:%03d)", val);
        else txt = $sformatf("(M2:%0d)", val);
      end
    endcase
    for (int i = 0; i < txt.len(); i++) msg.push_back(txt[i]);
    pick = $urandom_range(0, 99);
    if (pick >= 94) begin
      // long line that can run past the store and wrap the write position
      msg.delete();
      msg.push_back(CH_OPEN);
      repeat ($urandom_range(DEPTH - 2, 3 * DEPTH)) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_OPEN || b == CH_CLOSE) b = b ^ 8'h80;
        msg.push_back(b);
      end
      msg.push_back(CH_CLOSE);
    end else if (pick >= 88) begin
      msg.delete();
      repeat ($urandom_range(1, 20)) msg.push_back(8'($urandom_range(0, 255)));
    end else if (pick >= 83) begin
      void'(msg.pop_front());
    end else if (pick >= 72) begin
      pos = $urandom_range(0, msg.size() - 2);
      msg[pos] = 8'($urandom_range(0, 255));
    end
    foreach (msg[i]) begin
      tx_bytes.push_back(msg[i]);
      bytes_queued++;
    end
  endtask

  task automatic wait_drained();
    while (tx_bytes.size() != 0 || rx_if.valid || result_q.size() != 0) @(posedge clk_i);
  endtask

  // Byte driver
  always @(negedge clk_i) begin
    if (rst_ni && (!rx_if.valid || rx_took)) begin
      if (tx_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= tx_bytes.pop_front();
      end else begin
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'($urandom_range(0, 255));
      end
    end
  end

  // Result receiver; a long hold lets the output back up into the input
  always @(negedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt      <= hold_cnt - 1;
      resp_if.ready <= 1'b0;
    end else begin
      resp_if.ready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor, checker and watchdog
  always @(posedge clk_i) begin : mon
    cmd_result_t want;
    logic        got_in;
    logic        got_out;
    logic        busy;
    got_in  = rst_ni && rx_if.valid && rx_if.ready;
    got_out = rst_ni && resp_if.valid && resp_if.ready;
    busy    = tx_bytes.size() != 0 || rx_if.valid || result_q.size() != 0;
    rx_took <= got_in;
    if (got_out) begin
      results_seen <= results_seen + 1;
      if (result_q.size() == 0) begin
        if (mismatches < MAX_REPORT)
          $display("unexpected result word: resp=%0d run=%0b mode=%0d steps=%0d clr=%0b err=%0b",
                   resp_if.response, resp_if.running, resp_if.mode_now,
                   resp_if.step_count, resp_if.clear_counter, resp_if.error_sticky);
        mismatches <= mismatches + 1;
      end else begin
        want = result_q.pop_front();
        resp_count[want.response] <= resp_count[want.response] + 1;
        if (resp_if.response !== want.response || resp_if.running !== want.running ||
            resp_if.mode_now !== want.mode_now || resp_if.step_count !== want.step_count ||
            resp_if.clear_counter !== want.clear_counter ||
            resp_if.error_sticky !== want.error_sticky) begin
          if (mismatches < MAX_REPORT) begin
            $display("mismatch: expected resp=%0d run=%0b mode=%0d steps=%0d clr=%0b err=%0b",
                     want.response, want.running, want.mode_now, want.step_count,
                     want.clear_counter, want.error_sticky);
            $display("          got      resp=%0d run=%0b mode=%0d steps=%0d clr=%0b err=%0b",
                     resp_if.response, resp_if.running, resp_if.mode_now,
                     resp_if.step_count, resp_if.clear_counter, resp_if.error_sticky);
          end
          mismatches <= mismatches + 1;
        end
      end
    end
    if (got_in) take_byte(rx_if.rx_byte);
    if (got_in || got_out || !busy) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("serial_command_parser test failed");
      $finish;
    end
  end

  initial begin
    int unsigned target;
    int unsigned base_seen;
    foreach (line_buf[i]) line_buf[i] = 8'd0;
    foreach (resp_count[i]) resp_count[i] = 0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'd0;
    resp_if.ready = 1'b0;
    rst_ni        = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: byte extremes, every command, overflow, bad digit, stale head
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    bytes_queued += 2;
    push_text("(START)");
    push_text("(STOP)");
    push_text("(M1)");
    push_text("(M2:255)");
    push_text("(M2:256)");
    push_text("(M2::)");
    push_text("M1)");
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      target = bytes_queued + PHASE_LEN;
      while (bytes_queued < target) push_random_cmd();
      if (p == 0) begin
        base_seen = results_seen;
        while (results_seen < base_seen + 5) @(posedge clk_i);
        hold_cnt = HOLD_LEN;
      end
      // sender stops until every pending result is back
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    mismatches += result_q.size();
    $display("%0d bytes sent over four handshake phases, %0d command results checked",
             bytes_queued, results_seen);
    $display("started %0d, stopped %0d, mode 1 %0d, mode 2 %0d, format %0d, overflow %0d",
             resp_count[RESP_STARTED], resp_count[RESP_STOPPED], resp_count[RESP_MODE1],
             resp_count[RESP_MODE2], resp_count[RESP_FORMAT], resp_count[RESP_OVERFLOW]);
    if (mismatches == 0) begin
      $display("serial_command_parser test passed");
    end else begin
      $display("serial_command_parser test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/scp_pkg.sv
rtl/scp_in_if.sv
rtl/scp_out_if.sv
rtl/scp_cell.sv
rtl/serial_command_parser.sv
rtl/scp_checker.sv
tb/tb_top.sv
